### rtl/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 9;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_CMP,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic up_step;
        logic dn_load;
        logic dn_step;
        logic resp_load;
    } dp_cmd_t;

    typedef struct packed {
        logic go_up;
        logic go_dn;
        logic up_last;
        logic dn_last;
        logic out_busy;
    } dp_status_t;

endpackage

### rtl/mhpq_ram.sv
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### rtl/mhpq_ctrl.sv
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    priority if (dp_status.go_up)
                    begin
                        state_next = ST_UP_CMP;
                    end
                    else if (dp_status.go_dn)
                    begin
                        state_next = ST_DN_LOAD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_UP_CMP:
            begin
                dp_cmd.up_step = 1'b1;
                if (dp_status.up_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DN_LOAD:
            begin
                dp_cmd.dn_load = 1'b1;
                state_next     = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                dp_cmd.dn_step = 1'b1;
                if (dp_status.dn_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!dp_status.out_busy)
                begin
                    dp_cmd.resp_load = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mhpq_dp.sv
module mhpq_dp
    import mhpq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   dp_cmd,
    output dp_status_t                dp_status,
    input  logic                      req_type,
    input  logic signed [DATA_W-1:0]  push_value,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [DATA_W-1:0]  top_value,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      is_empty,
    output logic [1:0]                status
);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [ADDR_W-1:0]         pos_reg;
    logic [ADDR_W-1:0]         pos_next;
    logic signed [DATA_W-1:0]  val_reg;
    logic signed [DATA_W-1:0]  val_next;
    logic signed [DATA_W-1:0]  root_reg;
    status_t                   status_reg;
    status_t                   status_next;

    logic                      rsp_valid_reg;
    logic signed [DATA_W-1:0]  rsp_top_reg;
    logic [COUNT_W-1:0]        rsp_count_reg;
    logic                      rsp_empty_reg;
    status_t                   rsp_status_reg;

    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [DATA_W-1:0]         wdata;
    logic [ADDR_W-1:0]         raddr_a;
    logic [ADDR_W-1:0]         raddr_b;
    logic [DATA_W-1:0]         rdata_a;
    logic [DATA_W-1:0]         rdata_b;

    logic                      cnt_zero;
    logic                      cnt_full;
    logic [CNT_W-1:0]          cnt_dec;
    logic [ADDR_W-1:0]         pos_dec;
    logic [ADDR_W-1:0]         parent_idx;
    logic [ADDR_W-1:0]         parent_dec;
    logic                      up_move;
    logic [CHILD_W-1:0]        left_idx;
    logic [CHILD_W-1:0]        right_idx;
    logic                      left_ok;
    logic                      right_ok;
    logic                      sel_left;
    logic                      sel_right;
    logic signed [DATA_W-1:0]  best_val;
    logic                      dn_move;
    logic [ADDR_W-1:0]         dn_child;
    logic [DATA_W-1:0]         dn_child_val;
    logic [CHILD_W-1:0]        next_left;
    logic [CHILD_W-1:0]        next_right;

    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // index and compare helpers
    always_comb
    begin
        cnt_zero   = (count_reg == '0);
        cnt_full   = (count_reg == CNT_W'(CAPACITY));
        cnt_dec    = count_reg - CNT_W'(1);
        pos_dec    = pos_reg - ADDR_W'(1);
        parent_idx = pos_dec >> 1;
        parent_dec = parent_idx - ADDR_W'(1);
        up_move    = (pos_reg != '0) && (val_reg > $signed(rdata_a));

        left_idx   = {1'b0, pos_reg, 1'b1};
        right_idx  = left_idx + CHILD_W'(1);
        left_ok    = left_idx < CHILD_W'(count_reg);
        right_ok   = right_idx < CHILD_W'(count_reg);
        sel_left   = left_ok && ($signed(rdata_a) > val_reg);
        best_val   = sel_left ? $signed(rdata_a) : val_reg;
        sel_right  = right_ok && ($signed(rdata_b) > best_val);
        dn_move    = sel_left || sel_right;
        dn_child   = sel_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        dn_child_val = sel_right ? rdata_b : rdata_a;
        next_left  = {1'b0, dn_child, 1'b1};
        next_right = next_left + CHILD_W'(1);
    end

    always_comb
    begin
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = val_reg;
        raddr_a     = '0;
        raddr_b     = '0;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;

        if (dp_cmd.accept)
        begin
            status_next = STATUS_OK;
            if (req_type == REQ_PUSH)
            begin
                if (cnt_full)
                begin
                    status_next = STATUS_PUSH_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    pos_next   = count_reg[ADDR_W-1:0];
                    val_next   = push_value;
                    raddr_a    = ADDR_W'(cnt_dec >> 1);
                    if (cnt_zero)
                    begin
                        we    = 1'b1;
                        waddr = '0;
                        wdata = push_value;
                    end
                end
            end
            else
            begin
                if (cnt_zero)
                begin
                    status_next = STATUS_POP_EMPTY;
                end
                else
                begin
                    count_next = cnt_dec;
                    raddr_a    = ADDR_W'(cnt_dec);
                end
            end
        end
        else if (dp_cmd.up_step)
        begin
            we = 1'b1;
            if (up_move)
            begin
                wdata    = rdata_a;
                pos_next = parent_idx;
                raddr_a  = parent_dec >> 1;
            end
        end
        else if (dp_cmd.dn_load)
        begin
            val_next = $signed(rdata_a);
            pos_next = '0;
            raddr_a  = ADDR_W'(1);
            raddr_b  = ADDR_W'(2);
        end
        else if (dp_cmd.dn_step)
        begin
            we = 1'b1;
            if (dn_move)
            begin
                wdata    = dn_child_val;
                pos_next = dn_child;
                raddr_a  = next_left[ADDR_W-1:0];
                raddr_b  = next_right[ADDR_W-1:0];
            end
        end
    end

    always_comb
    begin
        dp_status.go_up    = (req_type == REQ_PUSH) && !cnt_zero && !cnt_full;
        dp_status.go_dn    = (req_type == REQ_POP) && (count_reg > CNT_W'(1));
        dp_status.up_last  = !up_move;
        dp_status.dn_last  = !dn_move;
        dp_status.out_busy = rsp_valid_reg && rsp_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= STATUS_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            if (dp_cmd.resp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working position and value, root mirror of heap entry zero and response register
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
        if (we && (waddr == '0))
        begin
            root_reg <= $signed(wdata);
        end
        if (dp_cmd.resp_load)
        begin
            rsp_top_reg    <= cnt_zero ? '0 : root_reg;
            rsp_count_reg  <= COUNT_W'(count_reg);
            rsp_empty_reg  <= cnt_zero;
            rsp_status_reg <= status_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign top_value   = rsp_top_reg;
    assign entry_count = rsp_count_reg;
    assign is_empty    = rsp_empty_reg;
    assign status      = rsp_status_reg;

endmodule

### rtl/max_heap_priority_queue_unit.sv
// max-heap priority queue of signed 32-bit values, up to CAPACITY entries
// request channel: req_valid/req_stall with req_type (0 push, 1 pop) and push_value
// response channel: rsp_valid/rsp_stall with top_value, entry_count, is_empty, status
// every request returns exactly one response describing the queue after it
// status 0 ok, 1 pop on empty queue, 2 push on full queue (store left unchanged)
// one request is worked at a time; req_stall is high from acceptance until the
// response is loaded into the output register
// push: after acceptance ST_UP_CMP climbs k levels (k <= log2 depth), then ST_RESP
// loads the response; pop: ST_DN_LOAD, then ST_DN_CMP descends k levels, then ST_RESP;
// a flagged request, a push into an empty queue or a pop of the last entry goes straight
// from acceptance to ST_RESP; the sift loop does one heap level per cycle through the
// two read ports of the heap ram
// reset empties the queue at once; heap contents need no clearing
// a stalled response is held in the output register; the next request can be taken
// meanwhile and its response waits until the register is free
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      req_type,
    input  logic signed [DATA_W-1:0]  push_value,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [DATA_W-1:0]  top_value,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      is_empty,
    output logic [1:0]                status
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    mhpq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .req_type    (req_type),
        .push_value  (push_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .top_value   (top_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while block idle after acceptance");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_empty) |-> (top_value == '0))
        else $error("empty queue reports nonzero top");

    a_pop_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STATUS_POP_EMPTY)) |-> is_empty)
        else $error("pop on empty flagged on nonempty queue");

    a_push_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STATUS_PUSH_FULL)) |-> !is_empty)
        else $error("push on full flagged on empty queue");

endmodule

### sim/max_heap_priority_queue_unit_tb.sv
`timescale 1ns / 100ps

module max_heap_priority_queue_unit_tb;

    import mhpq_pkg::*;

    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic [COUNT_W-1:0]       count;
        logic                     empty;
        status_t                  stat;
    } heap_rsp_t;

    class heap_mirror;
        logic signed [DATA_W-1:0] heap_vals [CAPACITY];
        int unsigned              fill;
        heap_rsp_t                rsp_backlog [$];
        int unsigned              mismatches;

        function void swap_vals(int unsigned a, int unsigned b);
            logic signed [DATA_W-1:0] tmp;
            tmp = heap_vals[a];
            heap_vals[a] = heap_vals[b];
            heap_vals[b] = tmp;
        endfunction

        function void note_request(logic kind, logic signed [DATA_W-1:0] value);
            heap_rsp_t   r;
            int unsigned i;
            int unsigned parent;
            int unsigned left;
            int unsigned right;
            int unsigned big;
            r.stat = STATUS_OK;
            if (kind == REQ_PUSH)
            begin
                if (fill >= CAPACITY)
                begin
                    r.stat = STATUS_PUSH_FULL;
                end
                else
                begin
                    heap_vals[fill] = value;
                    i = fill;
                    fill++;
                    while (i > 0)
                    begin
                        parent = (i - 1) / 2;
                        if (heap_vals[i] <= heap_vals[parent])
                            break;
                        swap_vals(i, parent);
                        i = parent;
                    end
                end
            end
            else
            begin
                if (fill == 0)
                begin
                    r.stat = STATUS_POP_EMPTY;
                end
                else
                begin
                    fill--;
                    heap_vals[0] = heap_vals[fill];
                    i = 0;
                    while (i < fill)
                    begin
                        left  = 2 * i + 1;
                        right = 2 * i + 2;
                        big   = i;
                        if (left < fill && heap_vals[left] > heap_vals[big])
                            big = left;
                        if (right < fill && heap_vals[right] > heap_vals[big])
                            big = right;
                        if (big == i)
                            break;
                        swap_vals(i, big);
                        i = big;
                    end
                end
            end
            r.top   = (fill > 0) ? heap_vals[0] : '0;
            r.count = COUNT_W'(fill);
            r.empty = (fill == 0);
            rsp_backlog.insert(rsp_backlog.size(), r);
        endfunction

        function void check_response(logic signed [DATA_W-1:0] top, logic [COUNT_W-1:0] count,
                                     logic empty, logic [1:0] stat);
            heap_rsp_t r;
            if (rsp_backlog.size() == 0)
            begin
                $error("response with no request pending");
                mismatches++;
                return;
            end
            r = rsp_backlog.pop_front();
            if (top !== r.top)
            begin
                $error("top_value: expected %0d, actual %0d", r.top, top);
                mismatches++;
            end
            if (count !== r.count)
            begin
                $error("entry_count: expected %0d, actual %0d", r.count, count);
                mismatches++;
            end
            if (empty !== r.empty)
            begin
                $error("is_empty: expected %0d, actual %0d", r.empty, empty);
                mismatches++;
            end
            if (stat !== r.stat)
            begin
                $error("status: expected %0d, actual %0d", r.stat, stat);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_type;
    logic signed [DATA_W-1:0] push_value;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic [1:0]               status;

    heap_mirror  mirror = new;
    int unsigned send_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned hold_requests;
    int unsigned push_pct;
    int unsigned forced_push;
    int unsigned forced_pop;

    max_heap_priority_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .push_value  (push_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .top_value   (top_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return DATA_W'($urandom);
        if (pick < 85)
            return DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
        case ($urandom_range(0, 3))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] value);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        push_value <= value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        mirror.note_request(kind, value);
    endtask

    task automatic wait_backlog_empty();
        req_valid <= 1'b0;
        @(posedge clk);
        while (mirror.rsp_backlog.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic kind;
        if (forced_push > 0)
        begin
            forced_push--;
            kind = REQ_PUSH;
        end
        else if (forced_pop > 0)
        begin
            forced_pop--;
            kind = REQ_POP;
        end
        else
        begin
            kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        end
        send_request(kind, random_value());
        // turn the walk around at the ends, poking past each one
        if (mirror.fill == CAPACITY && push_pct > 50)
        begin
            push_pct    = 20;
            forced_push = 3;
        end
        if (mirror.fill == 0 && push_pct < 50)
        begin
            push_pct   = 80;
            forced_pop = 2;
        end
    endtask

    // response side
    initial
    begin
        int unsigned holds_done;
        int unsigned hold_left;
        holds_done = 0;
        hold_left  = 0;
        rsp_stall  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                mirror.check_response(top_value, entry_count, is_empty, status);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_type      = REQ_PUSH;
        push_value    = '0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_requests = 0;
        push_pct      = 80;
        forced_push   = 0;
        forced_pop    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pops, extremes, equal keys, then drain past empty
        send_request(REQ_POP, random_value());
        send_request(REQ_POP, random_value());
        send_request(REQ_PUSH, 32'sh7fffffff);
        send_request(REQ_PUSH, 32'sh80000000);
        send_request(REQ_PUSH, '0);
        send_request(REQ_PUSH, '1);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_PUSH, 32'sh80000000);
        send_request(REQ_POP, 32'sh55555555);
        send_request(REQ_POP, 32'shaaaaaaaa);
        send_request(REQ_PUSH, 32'sh7fffffff);
        send_request(REQ_PUSH, 32'sh7fffffff);
        repeat (10)
            send_request(REQ_POP, random_value());
        wait_backlog_empty();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 48;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 48;
                end
                default:
                begin
                    send_idle_pct = 24;
                    rsp_stall_pct = 24;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 4 && (ph == 0 || ph == 3))
                begin
                    wait_backlog_empty();
                    hold_requests++;
                end
                random_request();
            end
        end

        wait_backlog_empty();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
